FILE: rtl/core/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared widths, item kinds and inter-module structs for the alias class
// merge table.
// ----------------------------------------------------------------------------
package acm_pkg;

	localparam int SYM_W    = 6;
	localparam int CLS_W    = 6;
	localparam int KIND_W   = 2;
	localparam int NCLS_W   = 7;
	localparam int NUM_SYMS = 1 << SYM_W;
	localparam int IDX_W    = $clog2(NUM_SYMS);
	localparam int CNT_W    = $clog2(NUM_SYMS + 1);

	localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

	localparam logic [NCLS_W-1:0] NCLS_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(NUM_SYMS);

	// Access request to the class memory: two read ports, one write port.
	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [CLS_W-1:0] wdata;
	} ram_req_t;

	// One result beat handed from the sequencer to the output register.
	typedef struct packed {
		logic             valid;
		logic             found;
		logic [CLS_W-1:0] class_id;
		logic [SYM_W-1:0] member;
		logic             member_valid;
		logic             last;
	} res_t;

endpackage

FILE: rtl/core/acm_class_ram.sv
// ----------------------------------------------------------------------------
// acm_class_ram
// Class id per symbol. Synchronous memory, two registered read ports and one
// write port; contents are undefined until written.
// ----------------------------------------------------------------------------
module acm_class_ram (
	input  logic                         clk,
	input  acm_pkg::ram_req_t            req,
	output logic [acm_pkg::CLS_W-1:0]    rdata_a,
	output logic [acm_pkg::CLS_W-1:0]    rdata_b
);
	import acm_pkg::*;

	logic [CLS_W-1:0] mem [NUM_SYMS];
	logic [CLS_W-1:0] rdata_a_q;
	logic [CLS_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Hold read data while no read is issued.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_a_q <= mem[req.raddr_a];
			rdata_b_q <= mem[req.raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

FILE: rtl/core/acm_ctrl.sv
// ----------------------------------------------------------------------------
// acm_ctrl
// Item sequencer: looks up both symbols, updates the class memory, runs the
// relabel and member-listing scans and produces result beats.
// ----------------------------------------------------------------------------
module acm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [acm_pkg::KIND_W-1:0]   kind,
	input  logic [acm_pkg::SYM_W-1:0]    sym_a,
	input  logic [acm_pkg::SYM_W-1:0]    sym_b,
	output acm_pkg::ram_req_t            ram_req,
	input  logic [acm_pkg::CLS_W-1:0]    rdata_a,
	input  logic [acm_pkg::CLS_W-1:0]    rdata_b,
	output acm_pkg::res_t                res,
	input  logic                         res_ready
);
	import acm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOOK  = 6'b000010,
		ST_WRB   = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_DONE  = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t              state_q, state_nxt;
	logic [NUM_SYMS-1:0] mapped_q;
	logic [NCLS_W-1:0]   next_class_q;
	logic [KIND_W-1:0]   kind_q;
	logic [SYM_W-1:0]    a_q, b_q;
	logic [CLS_W-1:0]    cls_q, src_q;
	logic                found_q;
	logic                relabel_q;
	logic [CNT_W-1:0]    idx_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                pend_vld_q;
	logic [IDX_W-1:0]    pend_idx_q;

	logic             ma, mb, is_merge;
	logic [CLS_W-1:0] new_id, match_cls;
	logic             hit, idx_lt, scan_end, stall, advance;

	assign ma        = mapped_q[a_q];
	assign mb        = mapped_q[b_q];
	assign is_merge  = (kind_q == KIND_MERGE);
	assign new_id    = next_class_q[CLS_W-1:0];
	assign match_cls = relabel_q ? src_q : cls_q;
	assign hit       = vld_s1 && mapped_q[idx_s1] && (rdata_a == match_cls);
	assign idx_lt    = (idx_q < CNT_END);
	assign scan_end  = !idx_lt && !vld_s1;
	assign stall     = !relabel_q && hit && pend_vld_q && !res_ready;
	assign advance   = (state_q == ST_SCAN) && !stall;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		ram_req   = '0;
		res       = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_req.re      = in_valid;
				ram_req.raddr_a = sym_a;
				ram_req.raddr_b = sym_b;
				if (in_valid) begin
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK: begin
				priority if (is_merge) begin
					priority if (!ma && !mb) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = a_q;
						ram_req.wdata = new_id;
						state_nxt     = ST_WRB;
					end else if (!ma) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = a_q;
						ram_req.wdata = rdata_b;
						state_nxt     = ST_DONE;
					end else if (!mb) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = b_q;
						ram_req.wdata = rdata_a;
						state_nxt     = ST_DONE;
					end else if (rdata_a != rdata_b) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_DONE;
					end
				end else if (kind_q == KIND_LIST && ma) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_WRB: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = b_q;
				ram_req.wdata = cls_q;
				state_nxt     = ST_DONE;
			end
			ST_SCAN: begin
				ram_req.re      = advance && idx_lt;
				ram_req.raddr_a = idx_q[IDX_W-1:0];
				if (relabel_q && hit) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = idx_s1;
					ram_req.wdata = cls_q;
				end
				// A new member pushes the pending one out; it is not the last.
				if (!relabel_q && hit && pend_vld_q) begin
					res.valid        = 1'b1;
					res.found        = 1'b1;
					res.class_id     = cls_q;
					res.member       = pend_idx_q;
					res.member_valid = 1'b1;
				end
				if (scan_end) begin
					state_nxt = relabel_q ? ST_DONE : ST_FLUSH;
				end
			end
			ST_DONE: begin
				res.valid    = 1'b1;
				res.found    = found_q;
				res.class_id = cls_q;
				res.last     = 1'b1;
				if (res_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				res.valid        = 1'b1;
				res.found        = 1'b1;
				res.class_id     = cls_q;
				res.member       = pend_idx_q;
				res.member_valid = 1'b1;
				res.last         = 1'b1;
				if (res_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mapped_q     <= '0;
			next_class_q <= '0;
			relabel_q    <= 1'b0;
			idx_q        <= '0;
			vld_s1       <= 1'b0;
			pend_vld_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_LOOK) begin
				if (is_merge) begin
					mapped_q[a_q] <= 1'b1;
					mapped_q[b_q] <= 1'b1;
					if (!ma && !mb && next_class_q != NCLS_MAX) begin
						next_class_q <= next_class_q + 1'b1;
					end
				end
				relabel_q  <= is_merge;
				idx_q      <= '0;
				vld_s1     <= 1'b0;
				pend_vld_q <= 1'b0;
			end
			if (advance) begin
				vld_s1 <= idx_lt;
				if (idx_lt) begin
					idx_q <= idx_q + 1'b1;
				end
				if (!relabel_q && hit) begin
					pend_vld_q <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH && res_ready) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q <= kind;
			a_q    <= sym_a;
			b_q    <= sym_b;
		end
		if (state_q == ST_LOOK) begin
			src_q <= rdata_b;
			if (is_merge) begin
				found_q <= 1'b1;
				priority if (!ma && !mb) begin
					cls_q <= new_id;
				end else if (!ma) begin
					cls_q <= rdata_b;
				end else begin
					cls_q <= rdata_a;
				end
			end else begin
				found_q <= ma;
				cls_q   <= ma ? rdata_a : '0;
			end
		end
		if (advance) begin
			if (idx_lt) begin
				idx_s1 <= idx_q[IDX_W-1:0];
			end
			if (!relabel_q && hit) begin
				pend_idx_q <= idx_s1;
			end
		end
	end

endmodule

FILE: rtl/core/alias_class_merge_table_top.sv
// ----------------------------------------------------------------------------
// alias_class_merge_table_top
// Equivalence classes over 64 symbols: merge, lookup and member listing.
// ----------------------------------------------------------------------------
// The block takes one item at a time on the slave stream and answers on the
// master stream. For a lookup, a merge that extends a class, or a merge of
// two symbols already in one class, the class memory is read, the result is
// formed and the result beat then sits in the output register. A merge that
// opens a new class also writes the second symbol in a state of its own. A
// merge of two different classes and a member listing walk every symbol
// entry through the single scan read port of the class memory, one entry per
// cycle; a listing also waits when a new member meets a stalled master side.
// s_tready rises again once the last result of the item has moved into the
// output register, so the next item is taken while that beat still waits on
// the master side. The mapped flags reset at once; no clearing pass runs
// after reset.
module alias_class_merge_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] sym_a, [11:6] sym_b, [15:12] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] found, [6:1] class_id, [12:7] member, [15:13] zero
	output logic [0:0]  m_tuser,   // [0] member_valid
	output logic        m_tlast
);
	import acm_pkg::*;

	ram_req_t         ram_req;
	logic [CLS_W-1:0] rdata_a, rdata_b;
	res_t             res;
	logic             res_ready;

	logic             m_tvalid_q;
	logic             found_q;
	logic [CLS_W-1:0] class_id_q;
	logic [SYM_W-1:0] member_q;
	logic             member_valid_q;
	logic             last_q;

	acm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser),
		.sym_a     (s_tdata[SYM_W-1:0]),
		.sym_b     (s_tdata[2*SYM_W-1:SYM_W]),
		.ram_req   (ram_req),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.res       (res),
		.res_ready (res_ready)
	);

	acm_class_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Output register: take a new beat when empty or when the held beat leaves.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res.valid;
		end
	end

	// Hold the payload while the beat is stalled.
	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			found_q        <= res.found;
			class_id_q     <= res.class_id;
			member_q       <= res.member;
			member_valid_q <= res.member_valid;
			last_q         <= res.last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {3'b000, member_q, class_id_q, found_q};
	assign m_tuser[0] = member_valid_q;
	assign m_tlast    = last_q;

endmodule

FILE: rtl/core/acm_checker.sv
// ----------------------------------------------------------------------------
// acm_checker
// Port-level checks on the result stream of the alias class merge table.
// ----------------------------------------------------------------------------
module acm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	// One item at a time: an accepted beat drops ready.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// Not found: class id zero, no member, single last beat.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0 && !m_tuser[0] && m_tlast)
		else $error("not-found result carries data");

	// A listed member always comes with a found class.
	a_member_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[0])
		else $error("member listed without a class");

	// Results without a member are single beats with a zero member field.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[12:7] == 6'd0)
		else $error("non-list result is not a single beat");

endmodule

bind alias_class_merge_table_top acm_checker u_acm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the alias class merge table. A short table of
// merges, lookups and listings opens, extends and joins classes from a clean
// reset. Random traffic follows with bursty input and a stalling output.
// Every output beat is checked field by field against a behavioral copy of
// the class table.
// ----------------------------------------------------------------------------
module tb_top;
	import acm_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int RST_CYC    = 4;
	localparam int IDLE_LIMIT = 4000;   // cycles without any beat on either side
	localparam int N_RANDOM   = 289;
	localparam int HOLD_CYC   = 40;     // hold-off after a full drain
	localparam int DRAIN_CYC  = 150;    // settle time after the last expected beat
	localparam int MAX_SHOWN  = 10;

	// Kind code 3 is not defined by the block; it behaves as a lookup.
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// One result beat as seen on the master side.
	typedef struct packed {
		logic             found;
		logic [CLS_W-1:0] class_id;
		logic [SYM_W-1:0] member;
		logic             member_valid;
		logic             last;
	} beat_t;

	// One directed stimulus row. When typed is set the single result beat is
	// given here (found, class_id, last = 1); otherwise it is predicted.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  sym_a;
		logic [SYM_W-1:0]  sym_b;
		logic              typed;
		logic              found;
		logic [CLS_W-1:0]  class_id;
	} row_t;

	localparam int N_ROWS = 21;
	localparam row_t DIRECTED_ROWS [N_ROWS] = '{
		// empty table after reset
		'{KIND_LOOKUP, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0},
		'{KIND_LIST,   6'd63, 6'd0,  1'b1, 1'b0, 6'd0},   // list of unknown symbol
		'{KIND_SPARE,  6'd5,  6'd63, 1'b1, 1'b0, 6'd0},   // unused kind acts as lookup
		// same symbol twice, both unmapped: opens a single-member class
		'{KIND_MERGE,  6'd0,  6'd0,  1'b1, 1'b1, 6'd0},
		'{KIND_MERGE,  6'd63, 6'd63, 1'b1, 1'b1, 6'd1},
		// only sym_b mapped: sym_a joins it
		'{KIND_MERGE,  6'd1,  6'd0,  1'b1, 1'b1, 6'd0},
		// neither mapped: new class
		'{KIND_MERGE,  6'd2,  6'd62, 1'b1, 1'b1, 6'd2},
		// only sym_a mapped: sym_b joins it
		'{KIND_MERGE,  6'd62, 6'd3,  1'b1, 1'b1, 6'd2},
		// two different classes: relabel sym_b's class
		'{KIND_MERGE,  6'd0,  6'd62, 1'b1, 1'b1, 6'd0},
		// both in one class: nothing changes
		'{KIND_MERGE,  6'd0,  6'd3,  1'b1, 1'b1, 6'd0},
		'{KIND_LIST,   6'd3,  6'd0,  1'b0, 1'b0, 6'd0},
		'{KIND_LIST,   6'd63, 6'd63, 1'b0, 1'b0, 6'd0},
		'{KIND_MERGE,  6'd63, 6'd1,  1'b0, 1'b0, 6'd0},
		'{KIND_LOOKUP, 6'd2,  6'd63, 1'b0, 1'b0, 6'd0},
		'{KIND_LIST,   6'd0,  6'd0,  1'b0, 1'b0, 6'd0},
		'{KIND_SPARE,  6'd62, 6'd0,  1'b0, 1'b0, 6'd0},
		'{KIND_LOOKUP, 6'd40, 6'd21, 1'b1, 1'b0, 6'd0},
		'{KIND_MERGE,  6'd42, 6'd21, 1'b0, 1'b0, 6'd0},
		'{KIND_LIST,   6'd21, 6'd42, 1'b0, 1'b0, 6'd0},
		'{KIND_MERGE,  6'd21, 6'd63, 1'b0, 1'b0, 6'd0},
		'{KIND_MERGE,  6'd42, 6'd5,  1'b0, 1'b0, 6'd0}
	};

	// DUT connections; every input is known from time zero.
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	alias_class_merge_table_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioral class table: a private copy of the partition, updated on
	// every accepted input beat, and the queue of beats it predicts.
	// ------------------------------------------------------------------------
	logic [CLS_W-1:0]  class_of_sym [NUM_SYMS];
	bit                sym_mapped   [NUM_SYMS];
	logic [NCLS_W-1:0] next_class_id = '0;
	beat_t             expected_beats [$];

	int kind_count [4];
	int joins_seen     = 0;
	int classes_opened = 0;
	int longest_list   = 0;
	int beats_checked  = 0;
	int err_count      = 0;
	int burst_left     = 0;

	initial begin
		for (int i = 0; i < NUM_SYMS; i++) begin
			sym_mapped[i]   = 1'b0;
			class_of_sym[i] = '0;
		end
		for (int k = 0; k < 4; k++) kind_count[k] = 0;
	end

	// Apply one accepted item to the table and queue the beats it causes.
	task automatic predict_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] a,
		input logic [SYM_W-1:0] b, input bit typed, input beat_t given);
		logic [CLS_W-1:0] ca;
		logic [CLS_W-1:0] cb;
		beat_t            bt;
		int               n_members;
		int               k;
		kind_count[kind]++;
		if (kind == KIND_MERGE) begin
			if (!sym_mapped[a] && !sym_mapped[b]) begin
				class_of_sym[a] = next_class_id[CLS_W-1:0];
				class_of_sym[b] = next_class_id[CLS_W-1:0];
				sym_mapped[a]   = 1'b1;
				sym_mapped[b]   = 1'b1;
				classes_opened++;
				if (next_class_id != NCLS_MAX) next_class_id++;
			end else if (!sym_mapped[a]) begin
				class_of_sym[a] = class_of_sym[b];
				sym_mapped[a]   = 1'b1;
			end else if (!sym_mapped[b]) begin
				class_of_sym[b] = class_of_sym[a];
				sym_mapped[b]   = 1'b1;
			end else begin
				ca = class_of_sym[a];
				cb = class_of_sym[b];
				if (ca != cb) begin
					joins_seen++;
					for (int i = 0; i < NUM_SYMS; i++)
						if (sym_mapped[i] && class_of_sym[i] == cb) class_of_sym[i] = ca;
				end
			end
		end

		bt      = '0;
		bt.last = 1'b1;
		if (typed) begin
			expected_beats.push_back(given);
		end else if (!sym_mapped[a]) begin
			expected_beats.push_back(bt);
		end else if (kind != KIND_LIST) begin
			bt.found    = 1'b1;
			bt.class_id = class_of_sym[a];
			expected_beats.push_back(bt);
		end else begin
			// sym_a is always among the members, so the listing is never empty
			n_members = 0;
			for (int i = 0; i < NUM_SYMS; i++)
				if (sym_mapped[i] && class_of_sym[i] == class_of_sym[a]) n_members++;
			if (n_members > longest_list) longest_list = n_members;
			k = 0;
			for (int i = 0; i < NUM_SYMS; i++) begin
				if (sym_mapped[i] && class_of_sym[i] == class_of_sym[a]) begin
					k++;
					bt.found        = 1'b1;
					bt.class_id     = class_of_sym[a];
					bt.member       = SYM_W'(i);
					bt.member_valid = 1'b1;
					bt.last         = (k == n_members);
					expected_beats.push_back(bt);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Input side. Each call starts at a rising edge, holds the beat until the
	// handshake edge and leaves tvalid high so back-to-back beats need no
	// second assignment in the same step.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] a,
		input logic [SYM_W-1:0] b, input bit typed, input beat_t given);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, b, a};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(kind, a, b, typed, given);
	endtask

	// Bursts of random length separated by random gaps; some gaps are zero so
	// long back-to-back stretches occur too.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold the input until every predicted beat has come out, then wait a bit.
	task automatic drain_pause();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (HOLD_CYC) @(posedge clk);
	endtask

	// Random symbol, biased toward mapped ones so queries see real classes.
	function automatic logic [SYM_W-1:0] pick_symbol(input bit prefer_mapped);
		logic [SYM_W-1:0] s;
		s = SYM_W'($urandom_range(0, NUM_SYMS - 1));
		if (prefer_mapped)
			for (int t = 0; t < 8 && !sym_mapped[s]; t++)
				s = SYM_W'($urandom_range(0, NUM_SYMS - 1));
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Output side: stall on a pattern of phases (always ready, coin flip,
	// long stall) so stalls land on every part of a listing.
	// ------------------------------------------------------------------------
	initial begin
		int len;
		int pick;
		@(posedge arst_n);
		forever begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				len = $urandom_range(10, 60);
				repeat (len) begin
					@(posedge clk);
					m_tready <= 1'b1;
				end
			end else if (pick < 7) begin
				len = $urandom_range(10, 40);
				repeat (len) begin
					@(posedge clk);
					m_tready <= $urandom_range(0, 1);
				end
			end else begin
				len = $urandom_range(1, 12);
				repeat (len) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
				@(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: compare each accepted result beat with the oldest prediction.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input bit have_want, input beat_t want,
		input beat_t got);
		err_count++;
		if (err_count <= MAX_SHOWN) begin
			if (have_want)
				$display("%0t: %s exp found=%0d cls=%0d mem=%0d mv=%0d last=%0d | got found=%0d cls=%0d mem=%0d mv=%0d last=%0d",
					$time, what, want.found, want.class_id, want.member, want.member_valid,
					want.last, got.found, got.class_id, got.member, got.member_valid, got.last);
			else
				$display("%0t: %s got found=%0d cls=%0d mem=%0d mv=%0d last=%0d",
					$time, what, got.found, got.class_id, got.member, got.member_valid, got.last);
		end
	endtask

	always @(posedge clk) begin : result_check
		beat_t got;
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found        = m_tdata[0];
			got.class_id     = m_tdata[6:1];
			got.member       = m_tdata[12:7];
			got.member_valid = m_tuser[0];
			got.last         = m_tlast;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected result beat:", 1'b0, '0, got);
			end else begin
				want = expected_beats.pop_front();
				if (got != want) report_mismatch("result mismatch:", 1'b1, want, got);
			end
		end
	end

	// Watchdog: any handshake on either side resets the idle count.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, expected_beats.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		row_t              row;
		beat_t             given;
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  a;
		logic [SYM_W-1:0]  b;
		int                pick;

		// single reset at the start of the run
		repeat (RST_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < N_ROWS; r++) begin
			row                = DIRECTED_ROWS[r];
			given              = '0;
			given.found        = row.found;
			given.class_id     = row.class_id;
			given.last         = 1'b1;
			if (r > 0) pace_sender();
			send_item(row.kind, row.sym_a, row.sym_b, row.typed, given);
		end

		// random traffic; merges keep growing and joining classes while
		// listings and lookups probe them
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 0 || i == 120 || i == 240)
				drain_pause();
			else
				pace_sender();
			pick = $urandom_range(0, 99);
			if (pick < 40)      kind = KIND_MERGE;
			else if (pick < 60) kind = KIND_LOOKUP;
			else if (pick < 88) kind = KIND_LIST;
			else                kind = KIND_SPARE;
			a = pick_symbol(kind != KIND_MERGE && $urandom_range(0, 3) != 0);
			b = (kind == KIND_MERGE) ? pick_symbol($urandom_range(0, 1) == 1)
			                         : SYM_W'($urandom);
			send_item(kind, a, b, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then let the block settle to catch stray beats
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("run: %0d merge, %0d lookup, %0d list, %0d unused-kind items; %0d beats checked",
			kind_count[KIND_MERGE], kind_count[KIND_LOOKUP], kind_count[KIND_LIST],
			kind_count[KIND_SPARE], beats_checked);
		$display("run: %0d classes opened, %0d class joins, longest listing %0d members",
			classes_opened, joins_seen, longest_list);
		if (err_count == 0 && expected_beats.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
